FILE: hw/rtl/alid_pkg.sv
// Package with the item types and operation and status codes of the positional list.
`default_nettype none
package alid_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_APPEND = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [6:0]         position;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [7:0]         moved;
    logic [7:0]         count;
    logic               is_empty_flag;
    logic               is_full_flag;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/alid_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module alid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/array_list_insert_delete.sv
// Top level of the positional list: insert, delete, read and append over a RAM store.
//
//   channel   ports                  handshake
//   -------   --------------------   ------------------------------------
//   command   start, busy, cmd       taken when start is high and busy low
//   result    done, result           done high for a single cycle per item, no back-pressure
//
// Append, insert at the end and every rejected item give their result in the
// cycle after they are taken. A read, or a delete that moves nothing, answers
// from S_RWAIT. An insert or delete that moves entries shifts them in S_SHIFT,
// one store entry per cycle through the single RAM write port. Reset clears the
// count and control state; the store needs no clearing pass. Busy stays high
// while an item is at work; results cannot be stalled.
`default_nettype none
module array_list_insert_delete #(
  parameter int CAPACITY = 128
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire alid_pkg::cmd_t   cmd,
  output logic                  done,
  output alid_pkg::result_t     result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RWAIT = 4'b0010,
    S_SHIFT = 4'b0100,
    S_LAST  = 4'b1000
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [1:0]    op;
  logic [AW-1:0] pos_r;
  logic [31:0]   val_r;
  logic [7:0]    moved_r;
  logic          shift_req;
  logic [AW-1:0] src;
  logic [AW-1:0] stop;
  logic [AW-1:0] wr_ptr;
  logic          issue;
  logic          pend;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic          is_full;
  logic          accept;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign pos_ext = PW'(cmd.position);
  assign cnt_ext = PW'(count);
  assign is_full = (count == CW'(CAPACITY));

  function automatic alid_pkg::result_t mk_result(input logic [31:0] v, input logic [1:0] st,
                                                  input logic [7:0] mv, input logic [CW-1:0] c);
    alid_pkg::result_t r;
    r.result_value  = v;
    r.status        = st;
    r.moved         = mv;
    r.count         = 8'(c);
    r.is_empty_flag = (c == '0);
    r.is_full_flag  = (c == CW'(CAPACITY));
    return r;
  endfunction

  alid_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // RAM port control. During a shift the read runs one entry ahead of the
  // write, so the two never touch the same address in one cycle.
  always_comb begin
    we    = 1'b0;
    waddr = wr_ptr;
    wdata = rdata;
    raddr = src;
    case (state)
      S_IDLE: begin
        raddr = AW'(pos_ext);
        waddr = AW'(cnt_ext);
        wdata = cmd.value;
        if (accept && !is_full) begin
          if (cmd.opcode == alid_pkg::OP_APPEND) begin
            we = 1'b1;
          end else if (cmd.opcode == alid_pkg::OP_INSERT && pos_ext == cnt_ext) begin
            we = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        we = pend;
      end
      S_LAST: begin
        we    = 1'b1;
        waddr = pos_r;
        wdata = val_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      issue <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= cmd.opcode;
            pos_r <= AW'(pos_ext);
            val_r <= cmd.value;
            pend  <= 1'b0;
            case (cmd.opcode)
              alid_pkg::OP_INSERT: begin
                if (is_full) begin
                  done   <= 1'b1;
                  result <= mk_result('0, alid_pkg::ST_FULL, '0, count);
                end else if (pos_ext > cnt_ext) begin
                  done   <= 1'b1;
                  result <= mk_result('0, alid_pkg::ST_BADPOS, '0, count);
                end else if (pos_ext == cnt_ext) begin
                  count  <= count + CW'(1);
                  done   <= 1'b1;
                  result <= mk_result('0, alid_pkg::ST_DONE, '0, count + CW'(1));
                end else begin
                  moved_r <= 8'(cnt_ext - pos_ext);
                  src     <= AW'(cnt_ext - PW'(1));
                  stop    <= AW'(pos_ext);
                  issue   <= 1'b1;
                  state   <= S_SHIFT;
                end
              end
              alid_pkg::OP_DELETE, alid_pkg::OP_READ: begin
                if (pos_ext >= cnt_ext) begin
                  done   <= 1'b1;
                  result <= mk_result('0, alid_pkg::ST_BADPOS, '0, count);
                end else begin
                  moved_r   <= 8'(cnt_ext - pos_ext - PW'(1));
                  shift_req <= (pos_ext + PW'(1) < cnt_ext);
                  src       <= AW'(pos_ext + PW'(1));
                  stop      <= AW'(cnt_ext - PW'(1));
                  state     <= S_RWAIT;
                end
              end
              default: begin
                if (is_full) begin
                  done   <= 1'b1;
                  result <= mk_result('0, alid_pkg::ST_FULL, '0, count);
                end else begin
                  count  <= count + CW'(1);
                  done   <= 1'b1;
                  result <= mk_result('0, alid_pkg::ST_DONE, '0, count + CW'(1));
                end
              end
            endcase
          end
        end
        S_RWAIT: begin
          // The entry at the position is on the read port now.
          val_r <= rdata;
          if (op == alid_pkg::OP_READ) begin
            done   <= 1'b1;
            result <= mk_result(rdata, alid_pkg::ST_DONE, '0, count);
            state  <= S_IDLE;
          end else if (shift_req) begin
            issue <= 1'b1;
            state <= S_SHIFT;
          end else begin
            count  <= count - CW'(1);
            done   <= 1'b1;
            result <= mk_result(rdata, alid_pkg::ST_DONE, moved_r, count - CW'(1));
            state  <= S_IDLE;
          end
        end
        S_SHIFT: begin
          pend <= issue;
          if (issue) begin
            wr_ptr <= (op == alid_pkg::OP_INSERT) ? src + AW'(1) : src - AW'(1);
            if (src == stop) begin
              issue <= 1'b0;
            end else begin
              src <= (op == alid_pkg::OP_INSERT) ? src - AW'(1) : src + AW'(1);
            end
          end else if (pend) begin
            // The last moved entry is written this cycle.
            pend <= 1'b0;
            if (op == alid_pkg::OP_INSERT) begin
              state <= S_LAST;
            end else begin
              count  <= count - CW'(1);
              done   <= 1'b1;
              result <= mk_result(val_r, alid_pkg::ST_DONE, moved_r, count - CW'(1));
              state  <= S_IDLE;
            end
          end
        end
        S_LAST: begin
          count  <= count + CW'(1);
          done   <= 1'b1;
          result <= mk_result('0, alid_pkg::ST_DONE, moved_r, count + CW'(1));
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the positional list with insert, delete, read and append.
module testbench;

  localparam int LIST_DEPTH = 128;
  localparam int REPORT_LIMIT = 10;
  localparam int STAGE_ITEMS = 544;

  class list_scoreboard;
    logic signed [31:0] entries [LIST_DEPTH];
    int fill;
    alid_pkg::result_t pending_results[$];
    int failures;

    function new();
      fill = 0;
      failures = 0;
      foreach (entries[k]) entries[k] = '0;
    endfunction

    // Applies one command to the shadow list and returns the result it should give.
    function alid_pkg::result_t list_outcome(alid_pkg::cmd_t c);
      alid_pkg::result_t r;
      int p;
      int k;
      r = '0;
      p = c.position;
      r.status = alid_pkg::ST_DONE;
      case (c.opcode)
        alid_pkg::OP_INSERT: begin
          if (fill >= LIST_DEPTH) begin
            r.status = alid_pkg::ST_FULL;
          end else if (p > fill) begin
            r.status = alid_pkg::ST_BADPOS;
          end else begin
            for (k = fill; k > p; k--) entries[k] = entries[k - 1];
            r.moved = 8'(fill - p);
            entries[p] = c.value;
            fill++;
          end
        end
        alid_pkg::OP_DELETE: begin
          if (p >= fill) begin
            r.status = alid_pkg::ST_BADPOS;
          end else begin
            r.result_value = entries[p];
            for (k = p; k + 1 < fill; k++) entries[k] = entries[k + 1];
            r.moved = 8'(fill - p - 1);
            fill--;
          end
        end
        alid_pkg::OP_READ: begin
          if (p >= fill) r.status = alid_pkg::ST_BADPOS;
          else r.result_value = entries[p];
        end
        default: begin
          if (fill >= LIST_DEPTH) begin
            r.status = alid_pkg::ST_FULL;
          end else begin
            entries[fill] = c.value;
            fill++;
          end
        end
      endcase
      r.count = 8'(fill);
      r.is_empty_flag = (fill == 0);
      r.is_full_flag = (fill == LIST_DEPTH);
      return r;
    endfunction

    function void note_command(alid_pkg::cmd_t c);
      pending_results.push_back(list_outcome(c));
    endfunction

    function void check_result(alid_pkg::result_t got);
      alid_pkg::result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: value=%0d status=%0d moved=%0d count=%0d",
                   got.result_value, got.status, got.moved, got.count);
        return;
      end
      want = pending_results.pop_front();
      if (got.result_value !== want.result_value || got.status !== want.status ||
          got.moved !== want.moved || got.count !== want.count ||
          got.is_empty_flag !== want.is_empty_flag ||
          got.is_full_flag !== want.is_full_flag) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("mismatch: expected value=%0d status=%0d moved=%0d count=%0d empty=%0b full=%0b",
                   want.result_value, want.status, want.moved, want.count,
                   want.is_empty_flag, want.is_full_flag);
          $display("          actual   value=%0d status=%0d moved=%0d count=%0d empty=%0b full=%0b",
                   got.result_value, got.status, got.moved, got.count,
                   got.is_empty_flag, got.is_full_flag);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  alid_pkg::cmd_t cmd;
  logic done;
  alid_pkg::result_t result;

  list_scoreboard board;

  array_list_insert_delete #(.CAPACITY(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst == 1'b0 && done === 1'b1) board.check_result(result);
  end

  function automatic alid_pkg::cmd_t make_cmd(logic [1:0] op, int pos, logic [31:0] val);
    alid_pkg::cmd_t c;
    c.opcode = op;
    c.position = 7'(pos);
    c.value = val;
    return c;
  endfunction

  // Holds the item on the port until the block takes it.
  task automatic issue(input alid_pkg::cmd_t c);
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    board.note_command(c);
  endtask

  task automatic random_gap(input int idle_pct);
    int n;
    n = 0;
    while ($urandom_range(99) < idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  // Growing favors insert and append, shrinking favors delete; most positions are in range.
  function automatic alid_pkg::cmd_t random_command(bit growing);
    alid_pkg::cmd_t c;
    int roll;
    int f;
    f = board.fill;
    roll = $urandom_range(99);
    if (growing)
      c.opcode = (roll < 40) ? alid_pkg::OP_INSERT :
                 (roll < 75) ? alid_pkg::OP_APPEND :
                 (roll < 85) ? alid_pkg::OP_DELETE : alid_pkg::OP_READ;
    else
      c.opcode = (roll < 10) ? alid_pkg::OP_INSERT :
                 (roll < 15) ? alid_pkg::OP_APPEND :
                 (roll < 75) ? alid_pkg::OP_DELETE : alid_pkg::OP_READ;
    c.position = 7'($urandom_range(127));
    if ($urandom_range(99) < 85) begin
      if (c.opcode == alid_pkg::OP_INSERT)
        c.position = 7'($urandom_range((f < LIST_DEPTH) ? f : LIST_DEPTH - 1, 0));
      else if (f > 0)
        c.position = 7'($urandom_range(f - 1, 0));
    end
    case ($urandom_range(19))
      0: c.value = 32'h7FFF_FFFF;
      1: c.value = 32'h8000_0000;
      2: c.value = 32'hFFFF_FFFF;
      3: c.value = 32'h0000_0000;
      default: c.value = $urandom;
    endcase
    return c;
  endfunction

  initial begin
    #40_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    bit growing;
    int idle_pct;
    board = new();
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Rejections on an empty list, then a short list built and taken apart.
    issue(make_cmd(alid_pkg::OP_READ, 0, 32'h0));
    issue(make_cmd(alid_pkg::OP_DELETE, 0, 32'h0));
    issue(make_cmd(alid_pkg::OP_DELETE, 127, 32'h1234_5678));
    issue(make_cmd(alid_pkg::OP_INSERT, 1, 32'h1111_1111));
    issue(make_cmd(alid_pkg::OP_INSERT, 127, 32'h2222_2222));
    issue(make_cmd(alid_pkg::OP_INSERT, 0, 32'h7FFF_FFFF));
    issue(make_cmd(alid_pkg::OP_APPEND, 0, 32'h8000_0000));
    issue(make_cmd(alid_pkg::OP_INSERT, 1, 32'hFFFF_FFFF));
    issue(make_cmd(alid_pkg::OP_INSERT, 0, 32'h0000_0000));
    issue(make_cmd(alid_pkg::OP_APPEND, 127, 32'h5555_5555));
    issue(make_cmd(alid_pkg::OP_READ, 4, 32'hAAAA_AAAA));
    issue(make_cmd(alid_pkg::OP_READ, 5, 32'h0));
    issue(make_cmd(alid_pkg::OP_READ, 127, 32'h0));
    issue(make_cmd(alid_pkg::OP_INSERT, 5, 32'hAAAA_AAAA));
    issue(make_cmd(alid_pkg::OP_INSERT, 7, 32'h1));
    issue(make_cmd(alid_pkg::OP_DELETE, 0, 32'hAAAA_AAAA));
    issue(make_cmd(alid_pkg::OP_DELETE, 4, 32'h0));
    issue(make_cmd(alid_pkg::OP_DELETE, 4, 32'h0));
    issue(make_cmd(alid_pkg::OP_DELETE, 1, 32'h0));
    issue(make_cmd(alid_pkg::OP_READ, 0, 32'h0));
    issue(make_cmd(alid_pkg::OP_READ, 1, 32'h0));
    wait_for_results();

    // Three stages: light sender gaps, heavy sender gaps, back to back.
    growing = 1'b1;
    for (int stage = 0; stage < 3; stage++) begin
      idle_pct = (stage == 0) ? 14 : (stage == 1) ? 87 : 0;
      for (int n = 0; n < STAGE_ITEMS; n++) begin
        if (growing && board.fill == LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
        else if (!growing && board.fill == 0 && $urandom_range(3) == 0) growing = 1'b1;
        random_gap(idle_pct);
        issue(random_command(growing));
      end
      wait_for_results();
    end

    repeat (LIST_DEPTH + 8) @(posedge clk);
    if (board.failures == 0 && board.pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: array_list_insert_delete.f
hw/rtl/alid_pkg.sv
hw/rtl/alid_ram.sv
hw/rtl/array_list_insert_delete.sv
verif/testbench.sv
